[hdl/gbm_antithetic_option_payoff_assert.svh]
// Assertion macros shared by the option payoff RTL.
`ifndef GBM_ANTITHETIC_OPTION_PAYOFF_ASSERT_SVH
`define GBM_ANTITHETIC_OPTION_PAYOFF_ASSERT_SVH
`ifndef SYNTHESIS
`define GBMAP_CHECK_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbmap check failed");
`define GBMAP_CHECK_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbmap check failed");
`else
`define GBMAP_CHECK_IMP(lbl, clk, rst, ante, cons)
`define GBMAP_CHECK_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/gbmap_pkg.sv]
// Shared types, constants and tables of the option payoff block.
`timescale 1ns / 1ps
package gbmap_pkg;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DRIFT     = 3'd0,
      REG_DIFFUSION = 3'd1,
      REG_SPOT      = 3'd2,
      REG_STRIKE    = 3'd3,
      REG_DISCOUNT  = 3'd4,
      REG_PUT       = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] drift;
      logic [30:0]        diffusion;
      logic [31:0]        spot;
      logic [31:0]        strike;
      logic [16:0]        discount;
      logic               is_put;
   } cfg_type;

   localparam logic [16:0] DISCOUNT_RESET = 17'd65536;
   localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
   localparam logic [30:0] LOG2E_Q30      = 31'd1549082005;
   localparam logic [29:0] LN2_Q30        = 30'd744261118;
   localparam longint      EXP_CLAMP      = 64'sd6442450944;
   localparam logic [3:0]  HORNER_TERMS   = 4'd9;

   // floor(2^33 / j) for the Horner divide by j
   function automatic logic [33:0] recip(input logic [3:0] j);
      logic [33:0] m;
      case (j)
         4'd1: m = 34'd8589934592;
         4'd2: m = 34'd4294967296;
         4'd3: m = 34'd2863311530;
         4'd4: m = 34'd2147483648;
         4'd5: m = 34'd1717986918;
         4'd6: m = 34'd1431655765;
         4'd7: m = 34'd1227133513;
         4'd8: m = 34'd1073741824;
         4'd9: m = 34'd954437176;
         default: m = 34'd0;
      endcase
      return m;
   endfunction

endpackage

[hdl/gbmap_if.sv]
// Handshake channel interfaces of the option payoff block.
`timescale 1ns / 1ps
interface gbmap_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_sample;
   logic               path_last;
   logic               clear_totals;
   modport source (output valid, normal_sample, path_last, clear_totals, input ready);
   modport sink (input valid, normal_sample, path_last, clear_totals, output ready);
endinterface

interface gbmap_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] path_payoff;
   logic [63:0] payoff_sum;
   logic [31:0] path_count;
   modport source (output valid, path_payoff, payoff_sum, path_count, input ready);
   modport sink (input valid, path_payoff, payoff_sum, path_count, output ready);
endinterface

interface gbmap_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [gbmap_pkg::CSR_INDEX_BITS-1:0] index;
   logic [31:0]                          data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/gbm_antithetic_option_payoff.sv]
// Top level of the antithetic GBM option payoff block.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   normal_sample, path_last, clear_totals
//   rsp_ch   out  valid/ready   path_payoff, payoff_sum, path_count
//   csr_ch   in   valid/ready   index, data (register write)
//
// Step items stream in at one item per cycle unless a path end waits on a full
// queue; the front end registers the scaled sample, then adds it into both log sums.
// A path end runs in the back end as two exponentials through one shared
// multiplier sequence (nine Horner steps, each an ST_HMUL, ST_HDIV, ST_HFIX pass).
// A two-entry queue holds path ends and clears; the input stalls only when it is full.
// Synchronous reset clears sums, totals, count and handshakes; no sweep.
`timescale 1ns / 1ps
module gbm_antithetic_option_payoff #(
   parameter int LOG_ACCUM_BITS = 48,
   parameter int COUNT_BITS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   gbmap_req_if.sink   req_ch,
   gbmap_rsp_if.source rsp_ch,
   gbmap_csr_if.sink   csr_ch
);
   localparam int QWIDTH = 2 * LOG_ACCUM_BITS + 2;

   gbmap_pkg::cfg_type cfg_ff, cfg_in;

   logic                             push_valid, push_ready, pop_valid, pop_ready;
   logic signed [LOG_ACCUM_BITS-1:0] push_main, push_mirror;
   logic                             push_last, push_clear;
   logic [QWIDTH-1:0]                push_data, pop_data;

   // register file: always ready, unknown indexes drop the write
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (gbmap_pkg::csr_reg_type'(csr_ch.index))
            gbmap_pkg::REG_DRIFT:     cfg_in.drift     = csr_ch.data;
            gbmap_pkg::REG_DIFFUSION: cfg_in.diffusion = csr_ch.data[30:0];
            gbmap_pkg::REG_SPOT:      cfg_in.spot      = csr_ch.data;
            gbmap_pkg::REG_STRIKE:    cfg_in.strike    = csr_ch.data;
            gbmap_pkg::REG_DISCOUNT:  cfg_in.discount  = csr_ch.data[16:0];
            gbmap_pkg::REG_PUT:       cfg_in.is_put    = csr_ch.data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drift     <= '0;
         cfg_ff.diffusion <= '0;
         cfg_ff.spot      <= '0;
         cfg_ff.strike    <= '0;
         cfg_ff.discount  <= gbmap_pkg::DISCOUNT_RESET;
         cfg_ff.is_put    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbmap_front #(.LOG_ACCUM_BITS(LOG_ACCUM_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .cfg         (cfg_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_main   (push_main),
      .push_mirror (push_mirror),
      .push_last   (push_last),
      .push_clear  (push_clear)
   );

   // pack the path-end entry for the queue
   assign push_data = {push_clear, push_last, push_mirror, push_main};

   gbmap_fifo #(.WIDTH(QWIDTH), .DEPTH(2)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gbmap_back #(.LOG_ACCUM_BITS(LOG_ACCUM_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_main   (pop_data[LOG_ACCUM_BITS-1:0]),
      .pop_mirror (pop_data[2*LOG_ACCUM_BITS-1:LOG_ACCUM_BITS]),
      .pop_last   (pop_data[QWIDTH-2]),
      .pop_clear  (pop_data[QWIDTH-1]),
      .rsp        (rsp_ch)
   );

endmodule

[hdl/gbmap_front.sv]
// Step front end: scales each sample and keeps the two log-return sums.
`timescale 1ns / 1ps
`include "gbm_antithetic_option_payoff_assert.svh"
module gbmap_front #(
   parameter int LOG_ACCUM_BITS = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   gbmap_req_if.sink                        req,
   input  gbmap_pkg::cfg_type               cfg,
   output logic                             push_valid,
   input  logic                             push_ready,
   output logic signed [LOG_ACCUM_BITS-1:0] push_main,
   output logic signed [LOG_ACCUM_BITS-1:0] push_mirror,
   output logic                             push_last,
   output logic                             push_clear
);
   localparam int SUM_BITS = LOG_ACCUM_BITS + 2;
   localparam logic signed [SUM_BITS-1:0] HI = SUM_BITS'((64'd1 << (LOG_ACCUM_BITS - 1)) - 64'd1);
   localparam logic signed [SUM_BITS-1:0] LO = -HI - SUM_BITS'(1);

   logic                             stage_vld_ff, stage_vld_in;
   logic signed [35:0]               term_ff, term_in;
   logic                             last_ff, last_in;
   logic                             clear_ff, clear_in;
   logic signed [LOG_ACCUM_BITS-1:0] main_ff, main_in;
   logic signed [LOG_ACCUM_BITS-1:0] mirror_ff, mirror_in;

   logic signed [31:0]               dif_s;
   logic signed [47:0]               prod;
   logic signed [36:0]               inc_p, inc_m;
   logic signed [LOG_ACCUM_BITS-1:0] main_new, mirror_new;
   logic                             needs_push, advance, take;

   function automatic logic signed [LOG_ACCUM_BITS-1:0] sat_fn(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] r;
      if (v > HI) r = HI;
      else if (v < LO) r = LO;
      else r = v;
      return LOG_ACCUM_BITS'(r);
   endfunction

   assign dif_s      = {1'b0, cfg.diffusion};
   assign prod       = dif_s * req.normal_sample;
   assign inc_p      = 37'(cfg.drift) + 37'(term_ff);
   assign inc_m      = 37'(cfg.drift) - 37'(term_ff);
   assign main_new   = sat_fn(SUM_BITS'(main_ff) + SUM_BITS'(inc_p));
   assign mirror_new = sat_fn(SUM_BITS'(mirror_ff) + SUM_BITS'(inc_m));

   // only path ends and clears go to the back end
   assign needs_push  = last_ff || clear_ff;
   assign advance     = stage_vld_ff && (!needs_push || push_ready);
   assign req.ready   = !stage_vld_ff || advance;
   assign take        = req.valid && req.ready;
   assign push_valid  = stage_vld_ff && needs_push;
   assign push_main   = main_new;
   assign push_mirror = mirror_new;
   assign push_last   = last_ff;
   assign push_clear  = clear_ff;

   always_comb begin
      stage_vld_in = stage_vld_ff;
      term_in      = term_ff;
      last_in      = last_ff;
      clear_in     = clear_ff;
      main_in      = main_ff;
      mirror_in    = mirror_ff;
      if (advance) begin
         stage_vld_in = 1'b0;
         if (last_ff) begin
            main_in   = '0;
            mirror_in = '0;
         end else begin
            main_in   = main_new;
            mirror_in = mirror_new;
         end
      end
      if (take) begin
         stage_vld_in = 1'b1;
         term_in      = prod[47:12];
         last_in      = req.path_last;
         clear_in     = req.clear_totals;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         main_ff      <= '0;
         mirror_ff    <= '0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         main_ff      <= main_in;
         mirror_ff    <= mirror_in;
      end
      term_ff  <= term_in;
      last_ff  <= last_in;
      clear_ff <= clear_in;
   end

   `GBMAP_CHECK_NXT(a_front_stage, clock, reset, take, stage_vld_ff)

endmodule

[hdl/gbmap_fifo.sv]
// Short queue of path-end and clear entries between front and back.
`timescale 1ns / 1ps
`include "gbm_antithetic_option_payoff_assert.svh"
module gbmap_fifo #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign push_ready = cnt_ff != CNT_BITS'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `GBMAP_CHECK_IMP(a_fifo_bound, clock, reset, 1'b1, cnt_ff <= CNT_BITS'(DEPTH))

endmodule

[hdl/gbmap_back.sv]
// Path-end sequencer: exp, price, payoff, discount and the running totals.
`timescale 1ns / 1ps
`include "gbm_antithetic_option_payoff_assert.svh"
module gbmap_back #(
   parameter int LOG_ACCUM_BITS = 48,
   parameter int COUNT_BITS     = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gbmap_pkg::cfg_type               cfg,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  logic signed [LOG_ACCUM_BITS-1:0] pop_main,
   input  logic signed [LOG_ACCUM_BITS-1:0] pop_mirror,
   input  logic                             pop_last,
   input  logic                             pop_clear,
   gbmap_rsp_if.source                      rsp
);
   localparam logic signed [LOG_ACCUM_BITS-1:0] EXPC =
      LOG_ACCUM_BITS'(gbmap_pkg::EXP_CLAMP);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_CLAMP = 12'b0000_0000_0010,
      ST_SPLIT = 12'b0000_0000_0100,
      ST_XFIN  = 12'b0000_0000_1000,
      ST_HMUL  = 12'b0000_0001_0000,
      ST_HDIV  = 12'b0000_0010_0000,
      ST_HFIX  = 12'b0000_0100_0000,
      ST_SPOT  = 12'b0000_1000_0000,
      ST_SHIFT = 12'b0001_0000_0000,
      ST_DISC  = 12'b0010_0000_0000,
      ST_DSAT  = 12'b0100_0000_0000,
      ST_ACCUM = 12'b1000_0000_0000
   } state_type;

   state_type                        state_ff, state_in;
   logic                             sel_ff, sel_in;
   logic signed [LOG_ACCUM_BITS-1:0] main_ff, main_in, mirror_ff, mirror_in;
   logic                             neg_ff, neg_in;
   logic [63:0]                      p_prod_ff, p_prod_in;
   logic signed [6:0]                k_ff, k_in;
   logic [59:0]                      xprod_ff, xprod_in;
   logic [29:0]                      x_ff, x_in;
   logic [30:0]                      t_ff, t_in;
   logic [3:0]                       j_ff, j_in;
   logic [60:0]                      hp_ff, hp_in;
   logic [30:0]                      q_ff, q_in;
   logic [64:0]                      qm_ff, qm_in;
   logic [63:0]                      sp_ff, sp_in;
   logic [31:0]                      price_ff, price_in;
   logic [48:0]                      dprod_ff, dprod_in;
   logic [31:0]                      a_ff, a_in, b_ff, b_in;
   logic [63:0]                      total_ff, total_in;
   logic [COUNT_BITS-1:0]            count_ff, count_in;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic [31:0]                      out_pay_ff, out_pay_in;
   logic [63:0]                      out_sum_ff, out_sum_in;
   logic [31:0]                      out_cnt_ff, out_cnt_in;

   logic signed [LOG_ACCUM_BITS-1:0] lsel, lclamp, lmag;
   logic signed [34:0]               y;
   logic [30:0]                      est, est_c;
   logic [34:0]                      rem;
   logic signed [7:0]                sh;
   logic [63:0]                      shifted;
   logic [2:0]                       ls;
   logic [31:0]                      iv, dsat;
   logic [32:0]                      pay_w;
   logic [64:0]                      tsum;
   logic                             out_free;

   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign pop_ready = state_ff == ST_IDLE;

   // clamp to +-24.0 and fold the sign out
   assign lsel   = sel_ff ? mirror_ff : main_ff;
   assign lclamp = (lsel > EXPC) ? EXPC : ((lsel < -EXPC) ? -EXPC : lsel);
   assign lmag   = lclamp[LOG_ACCUM_BITS-1] ? -lclamp : lclamp;

   assign y = neg_ff ? (35'sd0 - $signed({1'b0, p_prod_ff[63:30]}))
                     : $signed({1'b0, p_prod_ff[63:30]});

   // quotient estimate is low by at most one; fix it with the remainder
   assign est   = qm_ff[63:33];
   assign rem   = 35'(q_ff) - 35'(est) * 35'(j_ff);
   assign est_c = (rem >= 35'(j_ff)) ? est + 31'd1 : est;

   assign sh = 8'sd30 - 8'(k_ff);
   assign ls = 3'(-sh);

   always_comb begin
      if (sh > 8'sd63) begin
         shifted = '0;
      end else if (!sh[7]) begin
         shifted = sp_ff >> sh[5:0];
      end else if (sp_ff > ({64{1'b1}} >> ls)) begin
         shifted = {64{1'b1}};
      end else begin
         shifted = sp_ff << ls;
      end
   end

   always_comb begin
      if (cfg.is_put) iv = (cfg.strike > price_ff) ? cfg.strike - price_ff : '0;
      else iv = (price_ff > cfg.strike) ? price_ff - cfg.strike : '0;
   end

   // the discounted value overflows 32 bits only when the top product bit is set
   assign dsat  = dprod_ff[48] ? 32'hFFFF_FFFF : dprod_ff[47:16];
   assign pay_w = 33'(a_ff) + 33'(b_ff);
   assign tsum  = {1'b0, total_ff} + 65'(pay_w[32:1]);

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      main_in    = main_ff;
      mirror_in  = mirror_ff;
      neg_in     = neg_ff;
      p_prod_in  = p_prod_ff;
      k_in       = k_ff;
      xprod_in   = xprod_ff;
      x_in       = x_ff;
      t_in       = t_ff;
      j_in       = j_ff;
      hp_in      = hp_ff;
      q_in       = q_ff;
      qm_in      = qm_ff;
      sp_in      = sp_ff;
      price_in   = price_ff;
      dprod_in   = dprod_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      total_in   = total_ff;
      count_in   = count_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      out_pay_in = out_pay_ff;
      out_sum_in = out_sum_ff;
      out_cnt_in = out_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               main_in   = pop_main;
               mirror_in = pop_mirror;
               if (pop_clear) begin
                  total_in = '0;
                  count_in = '0;
               end
               if (pop_last) begin
                  sel_in   = 1'b0;
                  state_in = ST_CLAMP;
               end
            end
         end
         ST_CLAMP: begin
            neg_in    = lclamp[LOG_ACCUM_BITS-1];
            p_prod_in = 64'(lmag[32:0]) * 64'(gbmap_pkg::LOG2E_Q30);
            state_in  = ST_SPLIT;
         end
         ST_SPLIT: begin
            k_in     = y[34:28];
            xprod_in = 60'({y[27:0], 2'b00}) * 60'(gbmap_pkg::LN2_Q30);
            state_in = ST_XFIN;
         end
         ST_XFIN: begin
            x_in     = xprod_ff[59:30];
            t_in     = gbmap_pkg::ONE_Q30;
            j_in     = gbmap_pkg::HORNER_TERMS;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            hp_in    = 61'(x_ff) * 61'(t_ff);
            state_in = ST_HDIV;
         end
         ST_HDIV: begin
            q_in     = hp_ff[60:30];
            qm_in    = 65'(hp_ff[60:30]) * 65'(gbmap_pkg::recip(j_ff));
            state_in = ST_HFIX;
         end
         ST_HFIX: begin
            t_in = gbmap_pkg::ONE_Q30 + est_c;
            if (j_ff == 4'd1) begin
               state_in = ST_SPOT;
            end else begin
               j_in     = j_ff - 4'd1;
               state_in = ST_HMUL;
            end
         end
         ST_SPOT: begin
            sp_in    = 64'(cfg.spot) * 64'(t_ff);
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            price_in = (shifted > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : shifted[31:0];
            state_in = ST_DISC;
         end
         ST_DISC: begin
            dprod_in = 49'(iv) * 49'(cfg.discount);
            state_in = ST_DSAT;
         end
         ST_DSAT: begin
            if (!sel_ff) begin
               a_in     = dsat;
               sel_in   = 1'b1;
               state_in = ST_CLAMP;
            end else begin
               b_in     = dsat;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (out_free) begin
               total_in   = tsum[64] ? {64{1'b1}} : tsum[63:0];
               count_in   = (&count_ff) ? count_ff : count_ff + 1'b1;
               rsp_vld_in = 1'b1;
               out_pay_in = pay_w[32:1];
               out_sum_in = tsum[64] ? {64{1'b1}} : tsum[63:0];
               out_cnt_in = 32'((&count_ff) ? count_ff : count_ff + 1'b1);
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         total_ff   <= '0;
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      sel_ff     <= sel_in;
      main_ff    <= main_in;
      mirror_ff  <= mirror_in;
      neg_ff     <= neg_in;
      p_prod_ff  <= p_prod_in;
      k_ff       <= k_in;
      xprod_ff   <= xprod_in;
      x_ff       <= x_in;
      t_ff       <= t_in;
      j_ff       <= j_in;
      hp_ff      <= hp_in;
      q_ff       <= q_in;
      qm_ff      <= qm_in;
      sp_ff      <= sp_in;
      price_ff   <= price_in;
      dprod_ff   <= dprod_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      out_pay_ff <= out_pay_in;
      out_sum_ff <= out_sum_in;
      out_cnt_ff <= out_cnt_in;
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.path_payoff = out_pay_ff;
   assign rsp.payoff_sum  = out_sum_ff;
   assign rsp.path_count  = out_cnt_ff;

   `GBMAP_CHECK_IMP(a_back_horner_j, clock, reset, state_ff == ST_HMUL,
                    j_ff >= 4'd1 && j_ff <= gbmap_pkg::HORNER_TERMS)
   `GBMAP_CHECK_NXT(a_back_emit, clock, reset, state_ff == ST_ACCUM && out_free, rsp_vld_ff)

endmodule
